[design/eux_pkg.sv]
package eux_pkg;

  localparam int ANGLE_BITS    = 16;
  localparam int OUT_FRAC_BITS = 14;
  localparam int CORDIC_STAGES = 16;

  localparam int OUT_W    = OUT_FRAC_BITS + 2;
  localparam int CORDIC_N = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
  localparam int STG_W    = 5;
  localparam int WORK_W   = 34;   // Q4.30 working width for x, y and sums
  localparam int MUL_W    = 32;   // Q2.30 multiplier operand
  localparam int Z_W      = 33;   // residual angle, 2^32 = one turn
  localparam int RND_SH   = 30 - OUT_FRAC_BITS;

  localparam logic signed [WORK_W-1:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;

  localparam int LANE_X = 0;
  localparam int LANE_Y = 1;
  localparam int LANE_Z = 2;

  typedef struct packed {
    logic                    vld;
    logic [2:0][1:0]         quad;
    logic [2:0][WORK_W-1:0]  x;
    logic [2:0][WORK_W-1:0]  y;
    logic [2:0][Z_W-1:0]     z;
  } cordic_t;

  function automatic logic [Z_W-1:0] atan_lut(input logic [STG_W-1:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h20000000;  5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;  5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;  5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;  5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;  5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;  5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;  5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;  5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;  5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;  5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;  5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;  5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;  5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;  5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;  5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return {1'b0, v};
  endfunction

  // Q2.30 product with round half up
  function automatic logic signed [WORK_W-1:0] mul_q30(input logic signed [MUL_W-1:0] a,
                                                       input logic signed [MUL_W-1:0] b);
    logic signed [2*MUL_W-1:0] p;
    p = a * b + (64'sd1 <<< 29);
    return WORK_W'(p >>> 30);
  endfunction

endpackage

[design/eux_in_if.sv]
interface eux_in_if;
  import eux_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [ANGLE_BITS-1:0] angle_x;
  logic signed [ANGLE_BITS-1:0] angle_y;
  logic signed [ANGLE_BITS-1:0] angle_z;
  modport source (output valid, angle_x, angle_y, angle_z, input ready);
  modport sink   (input valid, angle_x, angle_y, angle_z, output ready);
endinterface

[design/eux_out_if.sv]
interface eux_out_if;
  import eux_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] m00, m10, m20, m01, m11, m21, m02, m12, m22;
  modport source (output valid, m00, m10, m20, m01, m11, m21, m02, m12, m22, input ready);
  modport sink   (input valid, m00, m10, m20, m01, m11, m21, m02, m12, m22, output ready);
endinterface

[design/eux_cordic_cell.sv]
module eux_cordic_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic [eux_pkg::STG_W-1:0]     stage_i,
  input  eux_pkg::cordic_t              d_i,
  output eux_pkg::cordic_t              q_o
);
  import eux_pkg::*;

  cordic_t                  data_d, data_q;
  logic                     vld_q;
  logic signed [WORK_W-1:0] xs, ys, dx, dy;
  logic [Z_W-1:0]           at;

  always_comb begin
    data_d = d_i;
    at     = atan_lut(stage_i);
    for (int l = 0; l < 3; l++) begin
      xs = $signed(d_i.x[l]);
      ys = $signed(d_i.y[l]);
      dx = ys >>> stage_i;
      dy = xs >>> stage_i;
      if (!d_i.z[l][Z_W-1]) begin
        data_d.x[l] = xs - dx;
        data_d.y[l] = ys + dy;
        data_d.z[l] = d_i.z[l] - at;
      end else begin
        data_d.x[l] = xs + dx;
        data_d.y[l] = ys - dy;
        data_d.z[l] = d_i.z[l] + at;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= d_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  always_comb begin
    q_o     = data_q;
    q_o.vld = vld_q;
  end
endmodule

[design/eux_matrix.sv]
module eux_matrix (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  eux_pkg::cordic_t d_i,
  eux_out_if.source        out_o
);
  import eux_pkg::*;

  localparam logic signed [WORK_W+1:0] RND = (RND_SH > 0) ? (36'sd1 <<< (RND_SH - 1)) : 36'sd0;
  localparam logic signed [OUT_W-1:0]  ONE = OUT_W'(1 << OUT_FRAC_BITS);

  function automatic logic signed [OUT_W-1:0] to_out(input logic signed [WORK_W-1:0] v);
    logic signed [WORK_W+1:0] r;
    r = ((WORK_W+2)'(v) + RND) >>> RND_SH;
    if (r > (WORK_W+2)'(ONE))       return ONE;
    else if (r < -(WORK_W+2)'(ONE)) return -ONE;
    else                            return OUT_W'(r);
  endfunction

  logic [2:0] vld_q;
  logic signed [MUL_W-1:0] c_d [3], s_d [3], c_q [3], s_q [3];
  // first products
  logic signed [WORK_W-1:0] czcy_q, szcy_q, szcx_q, szsx_q, czcx_q, czsx_q;
  logic signed [WORK_W-1:0] cycx_q, cysx_q, czsy_q, szsy_q;
  logic signed [MUL_W-1:0]  sy1_q, sx1_q, cx1_q;
  // triple products and carried terms
  logic signed [WORK_W-1:0] t1_q, t2_q, t3_q, t4_q;
  logic signed [WORK_W-1:0] czcy2_q, szcy2_q, szcx2_q, szsx2_q, czcx2_q, czsx2_q;
  logic signed [WORK_W-1:0] cycx2_q, cysx2_q, sy2_q;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      case (d_i.quad[l])
        QUAD_0: begin
          c_d[l] = MUL_W'(d_i.x[l]);  s_d[l] = MUL_W'(d_i.y[l]);
        end
        QUAD_1: begin
          c_d[l] = -MUL_W'(d_i.y[l]); s_d[l] = MUL_W'(d_i.x[l]);
        end
        QUAD_2: begin
          c_d[l] = -MUL_W'(d_i.x[l]); s_d[l] = -MUL_W'(d_i.y[l]);
        end
        default: begin
          c_d[l] = MUL_W'(d_i.y[l]);  s_d[l] = -MUL_W'(d_i.x[l]);
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_o.valid <= 1'b0;
    end else if (en_i) begin
      vld_q       <= {vld_q[1:0], d_i.vld};
      out_o.valid <= vld_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < 3; l++) begin
        c_q[l] <= c_d[l];
        s_q[l] <= s_d[l];
      end
      czcy_q <= mul_q30(c_q[LANE_Z], c_q[LANE_Y]);
      szcy_q <= mul_q30(s_q[LANE_Z], c_q[LANE_Y]);
      szcx_q <= mul_q30(s_q[LANE_Z], c_q[LANE_X]);
      szsx_q <= mul_q30(s_q[LANE_Z], s_q[LANE_X]);
      czcx_q <= mul_q30(c_q[LANE_Z], c_q[LANE_X]);
      czsx_q <= mul_q30(c_q[LANE_Z], s_q[LANE_X]);
      cycx_q <= mul_q30(c_q[LANE_Y], c_q[LANE_X]);
      cysx_q <= mul_q30(c_q[LANE_Y], s_q[LANE_X]);
      czsy_q <= mul_q30(c_q[LANE_Z], s_q[LANE_Y]);
      szsy_q <= mul_q30(s_q[LANE_Z], s_q[LANE_Y]);
      sy1_q  <= s_q[LANE_Y];
      sx1_q  <= s_q[LANE_X];
      cx1_q  <= c_q[LANE_X];

      t1_q    <= mul_q30(MUL_W'(czsy_q), sx1_q);
      t2_q    <= mul_q30(MUL_W'(czsy_q), cx1_q);
      t3_q    <= mul_q30(MUL_W'(szsy_q), sx1_q);
      t4_q    <= mul_q30(MUL_W'(szsy_q), cx1_q);
      czcy2_q <= czcy_q;
      szcy2_q <= szcy_q;
      szcx2_q <= szcx_q;
      szsx2_q <= szsx_q;
      czcx2_q <= czcx_q;
      czsx2_q <= czsx_q;
      cycx2_q <= cycx_q;
      cysx2_q <= cysx_q;
      sy2_q   <= WORK_W'(sy1_q);

      out_o.m00 <= to_out(czcy2_q);
      out_o.m10 <= to_out(szcx2_q + t1_q);
      out_o.m20 <= to_out(szsx2_q - t2_q);
      out_o.m01 <= to_out(-szcy2_q);
      out_o.m11 <= to_out(czcx2_q - t3_q);
      out_o.m21 <= to_out(czsx2_q + t4_q);
      out_o.m02 <= to_out(sy2_q);
      out_o.m12 <= to_out(-cysx2_q);
      out_o.m22 <= to_out(cycx2_q);
    end
  end
endmodule

[design/euler_xyz_to_rotation_matrix.sv]
// Euler x-y-z angles to 3x3 rotation matrix. Each request carries three signed binary
// angles (half scale = pi); the result carries the nine Q1.14 entries, rounded and
// clamped to +/-1. Fully pipelined: a new request is taken every cycle unless stalled,
// and each request passes the register in each CORDIC cell, then quadrant fix-up, two
// multiply stages and the output register. The whole pipeline holds while the output
// register is full and not taken.
module euler_xyz_to_rotation_matrix (
  input  logic      clk_i,
  input  logic      rst_ni,
  eux_in_if.sink    in_i,
  eux_out_if.source out_o
);
  import eux_pkg::*;

  logic             en;
  cordic_t          chain [CORDIC_N+1];
  logic [CORDIC_N:0] chain_vld;
  logic [31:0]      al [3];

  assign en         = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  always_comb begin
    al[LANE_X] = 32'(unsigned'(in_i.angle_x)) << (32 - ANGLE_BITS);
    al[LANE_Y] = 32'(unsigned'(in_i.angle_y)) << (32 - ANGLE_BITS);
    al[LANE_Z] = 32'(unsigned'(in_i.angle_z)) << (32 - ANGLE_BITS);
    chain[0].vld = in_i.valid;
    for (int l = 0; l < 3; l++) begin
      chain[0].quad[l] = al[l][31:30];
      chain[0].x[l]    = CORDIC_GAIN;
      chain[0].y[l]    = '0;
      chain[0].z[l]    = {3'b000, al[l][29:0]};
    end
  end

  for (genvar k = 0; k < CORDIC_N; k++) begin : g_cell
    eux_cordic_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .stage_i (STG_W'(k)),
      .d_i     (chain[k]),
      .q_o     (chain[k+1])
    );
  end

  for (genvar k = 0; k <= CORDIC_N; k++) begin : g_vld
    assign chain_vld[k] = chain[k].vld;
  end

  eux_matrix u_matrix (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .d_i    (chain[CORDIC_N]),
    .out_o  (out_o)
  );

`ifndef NO_ASSERTIONS
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready == (!out_o.valid || out_o.ready)) else $error("ready mismatch");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(chain_vld[CORDIC_N:1])) else $error("pipeline moved while stalled");
  a_m00: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.m00 <= 16'sd16384 && out_o.m00 >= -16'sd16384))
    else $error("m00 out of range");
  a_m11: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.m11 <= 16'sd16384 && out_o.m11 >= -16'sd16384))
    else $error("m11 out of range");
`endif
endmodule

[dv/eux_tb_if.sv]
package eux_tb_pkg;
  import eux_pkg::*;

  typedef struct packed {
    logic signed [OUT_W-1:0] m00, m10, m20, m01, m11, m21, m02, m12, m22;
  } rot_mat_t;

  class rot_scoreboard;
    rot_mat_t pending_q[$];
    int       n_req;
    int       n_res;
    int       n_err;

    static function automatic longint q30_mul(longint a, longint b);
      return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    static function automatic void angle_sincos(logic [ANGLE_BITS-1:0] ang,
                                                output longint c, output longint s);
      logic [31:0] a32;
      logic [1:0]  quad;
      longint      x, y, z, dx, dy;
      logic [31:0] step_atan [32];
      step_atan = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
                    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
                    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
                    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
                    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
                    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
                    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
                    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000};
      a32  = 32'(ang) << (32 - ANGLE_BITS);
      quad = a32[31:30];
      x    = 652032874;
      y    = 0;
      z    = longint'(a32[29:0]);
      for (int i = 0; i < CORDIC_N; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= longint'(step_atan[i]);
        end else begin
          x += dx; y -= dy; z += longint'(step_atan[i]);
        end
      end
      case (quad)
        QUAD_0:  begin c = x;  s = y;  end
        QUAD_1:  begin c = -y; s = x;  end
        QUAD_2:  begin c = -x; s = -y; end
        default: begin c = y;  s = -x; end
      endcase
    endfunction

    static function automatic logic signed [OUT_W-1:0] to_entry(longint v);
      longint one, r;
      one = longint'(1) <<< OUT_FRAC_BITS;
      r   = v;
      if (RND_SH > 0) r = (v + (longint'(1) <<< (RND_SH - 1))) >>> RND_SH;
      if (r > one) r = one;
      if (r < -one) r = -one;
      return OUT_W'(r);
    endfunction

    function automatic rot_mat_t rotation_of(logic [ANGLE_BITS-1:0] ax,
                                             logic [ANGLE_BITS-1:0] ay,
                                             logic [ANGLE_BITS-1:0] az);
      longint cx, sx, cy, sy, cz, sz, czsy, szsy;
      rot_mat_t m;
      angle_sincos(ax, cx, sx);
      angle_sincos(ay, cy, sy);
      angle_sincos(az, cz, sz);
      czsy  = q30_mul(cz, sy);
      szsy  = q30_mul(sz, sy);
      m.m00 = to_entry(q30_mul(cz, cy));
      m.m10 = to_entry(q30_mul(sz, cx) + q30_mul(czsy, sx));
      m.m20 = to_entry(q30_mul(sz, sx) - q30_mul(czsy, cx));
      m.m01 = to_entry(-q30_mul(sz, cy));
      m.m11 = to_entry(q30_mul(cz, cx) - q30_mul(szsy, sx));
      m.m21 = to_entry(q30_mul(cz, sx) + q30_mul(szsy, cx));
      m.m02 = to_entry(sy);
      m.m12 = to_entry(-q30_mul(cy, sx));
      m.m22 = to_entry(q30_mul(cy, cx));
      return m;
    endfunction

    function void note_request(logic [ANGLE_BITS-1:0] ax, logic [ANGLE_BITS-1:0] ay,
                               logic [ANGLE_BITS-1:0] az);
      pending_q.push_back(rotation_of(ax, ay, az));
      n_req++;
    endfunction

    function void check_matrix(rot_mat_t got);
      rot_mat_t exp_m;
      n_res++;
      if (pending_q.size() == 0) begin
        $error("matrix with no request outstanding");
        n_err++;
        return;
      end
      exp_m = pending_q.pop_front();
      if (got.m00 !== exp_m.m00) begin $error("m00 exp %0d got %0d", exp_m.m00, got.m00); n_err++; end
      if (got.m10 !== exp_m.m10) begin $error("m10 exp %0d got %0d", exp_m.m10, got.m10); n_err++; end
      if (got.m20 !== exp_m.m20) begin $error("m20 exp %0d got %0d", exp_m.m20, got.m20); n_err++; end
      if (got.m01 !== exp_m.m01) begin $error("m01 exp %0d got %0d", exp_m.m01, got.m01); n_err++; end
      if (got.m11 !== exp_m.m11) begin $error("m11 exp %0d got %0d", exp_m.m11, got.m11); n_err++; end
      if (got.m21 !== exp_m.m21) begin $error("m21 exp %0d got %0d", exp_m.m21, got.m21); n_err++; end
      if (got.m02 !== exp_m.m02) begin $error("m02 exp %0d got %0d", exp_m.m02, got.m02); n_err++; end
      if (got.m12 !== exp_m.m12) begin $error("m12 exp %0d got %0d", exp_m.m12, got.m12); n_err++; end
      if (got.m22 !== exp_m.m22) begin $error("m22 exp %0d got %0d", exp_m.m22, got.m22); n_err++; end
    endfunction
  endclass
endpackage

[dv/euler_xyz_to_rotation_matrix_tb.sv]
module euler_xyz_to_rotation_matrix_tb;
  import eux_pkg::*;
  import eux_tb_pkg::*;

  localparam int LATENCY   = CORDIC_STAGES + 4;
  localparam int MAX_CYC   = 400000;
  localparam int N_RANDOM  = 1430;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  eux_in_if  req_if ();
  eux_out_if mat_if ();

  euler_xyz_to_rotation_matrix dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if.sink),
    .out_o  (mat_if.source)
  );

  always #5 clk_i = ~clk_i;

  rot_scoreboard sb = new();

  int  src_idle_pct  = 0;
  int  sink_stall_pct = 0;
  bit  hold_off      = 1'b0;
  int  cycle_cnt     = 0;

  initial begin
    req_if.valid   = 1'b0;
    req_if.angle_x = '0;
    req_if.angle_y = '0;
    req_if.angle_z = '0;
    mat_if.ready   = 1'b0;
  end

  // timeout watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MAX_CYC) begin
      $display("euler_xyz_to_rotation_matrix_tb NOT OK");
      $finish;
    end
  end

  // result side: random stall, plus the long hold-off window
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (mat_if.valid && mat_if.ready)
        sb.check_matrix({mat_if.m00, mat_if.m10, mat_if.m20, mat_if.m01, mat_if.m11,
                         mat_if.m21, mat_if.m02, mat_if.m12, mat_if.m22});
      mat_if.ready <= !hold_off && ($urandom_range(99) >= sink_stall_pct);
    end
  end

  task automatic send_request(logic [ANGLE_BITS-1:0] ax, logic [ANGLE_BITS-1:0] ay,
                              logic [ANGLE_BITS-1:0] az);
    while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.angle_x <= ax;
    req_if.angle_y <= ay;
    req_if.angle_z <= az;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    sb.note_request(ax, ay, az);
  endtask

  function automatic logic [ANGLE_BITS-1:0] pick_angle();
    logic [ANGLE_BITS-1:0] quarter;
    quarter = ANGLE_BITS'(1 << (ANGLE_BITS - 2));
    case ($urandom_range(5))
      0: return ANGLE_BITS'(quarter * $urandom_range(3));       // quadrant boundary
      1: return ANGLE_BITS'(quarter * $urandom_range(3) + $urandom_range(3) - 2); // near it
      default: return ANGLE_BITS'($urandom);
    endcase
  endfunction

  initial begin
    logic [ANGLE_BITS-1:0] corner [8];
    int phase;
    corner = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
               16'h7FFF, 16'h0001, 16'hFFFF, 16'h2000};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, quadrant edges, gimbal lock around y = +/-pi/2
    for (int i = 0; i < 8; i++)
      send_request(corner[i], corner[(i + 3) % 8], corner[(i + 5) % 8]);
    send_request(16'h8000, 16'h8000, 16'h8000);
    send_request(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_request(16'h1234, 16'h4000, 16'hABCD);
    send_request(16'h9876, 16'hC000, 16'h5555);
    send_request(16'hFFFF, 16'h0000, 16'h0001);
    send_request(16'h3FFF, 16'h4001, 16'hBFFF);

    for (int n = 0; n < N_RANDOM; n++) begin
      phase = (n * 6) / N_RANDOM;
      case (phase)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 45; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 45; end
        3: begin src_idle_pct = 21; sink_stall_pct = 21; end
        4: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        default: begin src_idle_pct = 45; sink_stall_pct = 45; end
      endcase
      // long output hold-off at the last request of phase 3, just before phase 4, so the pipe backs up
      if (n == (4 * N_RANDOM) / 6) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (200) @(posedge clk_i);
            hold_off = 1'b0;
          end
        join_none
      end
      send_request(pick_angle(), pick_angle(), pick_angle());
    end
    req_if.valid <= 1'b0;
    sink_stall_pct = 0;

    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);

    $display("sent %0d requests, checked %0d matrices across idle/stall phases",
             sb.n_req, sb.n_res);
    if (sb.n_err == 0 && sb.pending_q.size() == 0)
      $display("euler_xyz_to_rotation_matrix_tb OK");
    else
      $display("euler_xyz_to_rotation_matrix_tb NOT OK");
    $finish;
  end
endmodule

[files.f]
design/eux_pkg.sv
design/eux_in_if.sv
design/eux_out_if.sv
design/eux_cordic_cell.sv
design/eux_matrix.sv
design/euler_xyz_to_rotation_matrix.sv
dv/eux_tb_if.sv
dv/euler_xyz_to_rotation_matrix_tb.sv
